// ===== hw/rtl/sro_pkg.sv =====
// ----------------------------------------------------------------------------
// sro_pkg: shared types and constants of the sequence reorder buffer
// Store depth, field widths, function and status codes, cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package sro_pkg;

	// store geometry
	localparam int SLOTS = 16;
	localparam int CNT_W = $clog2(SLOTS + 1);

	// field widths
	localparam int SEQ_W  = 31;
	localparam int PAY_W  = 32;
	localparam int TOK_W  = 32;
	localparam int CID_W  = 16;
	localparam int CSEQ_W = 32;

	// function codes
	typedef enum logic [1:0] {
		FN_RECEIVE = 2'd0,
		FN_RELEASE = 2'd1,
		FN_RESET   = 2'd2,
		FN_UNUSED  = 2'd3
	} func_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_STORED   = 3'd0,
		ST_STALE    = 3'd1,
		ST_DUP      = 3'd2,
		ST_FULL     = 3'd3,
		ST_RELEASED = 3'd4,
		ST_NONE     = 3'd5,
		ST_RESET    = 3'd6
	} status_t;

	// control word broadcast to every cell
	typedef struct packed {
		logic             ins;
		logic             rel;
		logic [SEQ_W-1:0] seq;
		logic [PAY_W-1:0] pay;
	} sro_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sro_cell.sv =====
// ----------------------------------------------------------------------------
// sro_cell: one entry of the sorted store
// Holds a sequence number and payload, compares against the broadcast word,
// takes the new word or its left neighbor on insert, its right neighbor on release.
// ----------------------------------------------------------------------------
`default_nettype none

module sro_cell import sro_pkg::*; (
	input  wire logic             clk,
	input  wire sro_ctrl_t        ctrl,
	input  wire logic             occ,
	input  wire logic             prev_gt,
	input  wire logic [SEQ_W-1:0] prev_seq,
	input  wire logic [PAY_W-1:0] prev_pay,
	input  wire logic [SEQ_W-1:0] next_seq,
	input  wire logic [PAY_W-1:0] next_pay,
	output logic      [SEQ_W-1:0] seq,
	output logic      [PAY_W-1:0] pay,
	output logic                  gt,
	output logic                  eq,
	output logic                  link
);

	logic [SEQ_W-1:0] seq_q;
	logic [PAY_W-1:0] pay_q;

	// entry sits at or after the insert point
	assign gt = !occ || (seq_q > ctrl.seq);
	assign eq = occ && (seq_q == ctrl.seq);

	// number follows its left neighbor without a gap
	assign link = ({1'b0, seq_q} <= ({1'b0, prev_seq} + (SEQ_W+1)'(1)));

	assign seq = seq_q;
	assign pay = pay_q;

	// insert shifts right from the insert point, release shifts left
	always_ff @(posedge clk) begin
		if (ctrl.ins && gt) begin
			if (prev_gt) begin
				seq_q <= prev_seq;
				pay_q <= prev_pay;
			end else begin
				seq_q <= ctrl.seq;
				pay_q <= ctrl.pay;
			end
		end else if (ctrl.rel) begin
			seq_q <= next_seq;
			pay_q <= next_pay;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sequence_reorder_buffer_top.sv =====
// Flow: an accepted word loads the status and output registers and sets the walk flag;
// the walk then resolves the contiguous number across the cell chain and raises done,
// which marks the result. busy is high during the walk, so a new word cannot be
// accepted until the walk is over.
// Reset: count cleared, contiguous number and connection id set to -1,
// join token cleared; cell contents are not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_top: in-order packet reorder buffer
// Sorted chain of cells with hello handling, stale/duplicate/full drop,
// head release and contiguous number tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_reorder_buffer_top import sro_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               func,
	input  wire logic [SEQ_W-1:0]         seq_id,
	input  wire logic [PAY_W-1:0]         payload,
	input  wire logic                     is_hello,
	input  wire logic [TOK_W-1:0]         echoed_token,
	input  wire logic [CID_W-1:0]         offered_conn_id,
	input  wire logic signed [CSEQ_W-1:0] last_processed,
	input  wire logic                     cfg_we,
	input  wire logic [TOK_W-1:0]         cfg_wdata,
	output logic                          done,
	output logic [2:0]                    status,
	output logic [SEQ_W-1:0]              out_seq,
	output logic [PAY_W-1:0]              out_payload,
	output logic signed [CSEQ_W-1:0]      contiguous_seq,
	output logic signed [CID_W:0]         conn_id
);

	logic [TOK_W-1:0]         token_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [CSEQ_W-1:0] contig_q;
	logic signed [CID_W:0]    conn_q;
	logic                     walk_q;
	logic                     walk_en_q;
	logic                     done_q;
	status_t                  status_q;
	logic [SEQ_W-1:0]         out_seq_q;
	logic [PAY_W-1:0]         out_pay_q;

	logic [SEQ_W-1:0] cell_seq  [SLOTS];
	logic [PAY_W-1:0] cell_pay  [SLOTS];
	logic [SLOTS-1:0] cell_gt;
	logic [SLOTS-1:0] cell_eq;
	logic [SLOTS-1:0] cell_link;
	logic [SLOTS-1:0] occ;

	sro_ctrl_t ctrl;
	logic      accept;
	logic      is_recv;
	logic      is_rel;
	logic      is_rst;
	logic      stale;
	logic      dup;
	logic      full;
	logic      rel_ok;
	logic      hello_take;
	logic signed [CSEQ_W:0] contig_x;

	assign accept = start && !busy;
	assign busy   = walk_q;

	assign is_recv = (func == FN_RECEIVE);
	assign is_rel  = (func == FN_RELEASE);
	assign is_rst  = (func == FN_RESET);

	// classification of a received word
	assign contig_x = {contig_q[CSEQ_W-1], contig_q};
	assign stale    = ($signed({2'b00, seq_id}) <= contig_x);
	assign dup      = |cell_eq;
	assign full     = (count_q == CNT_W'(SLOTS));

	// head release check
	assign rel_ok = occ[0] &&
		($signed({2'b00, cell_seq[0]}) ==
		 ({last_processed[CSEQ_W-1], last_processed} + (CSEQ_W+1)'(1)));

	assign hello_take = is_hello && (conn_q == '1) && (echoed_token == token_q);

	// cell control word
	assign ctrl.ins = accept && is_recv && !stale && !dup && !full;
	assign ctrl.rel = accept && is_rel && rel_ok;
	assign ctrl.seq = seq_id;
	assign ctrl.pay = payload;

	// chain of cells
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic             prev_gt_w;
		logic [SEQ_W-1:0] prev_seq_w;
		logic [PAY_W-1:0] prev_pay_w;
		logic [SEQ_W-1:0] next_seq_w;
		logic [PAY_W-1:0] next_pay_w;

		assign occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign prev_gt_w  = 1'b0;
			assign prev_seq_w = '0;
			assign prev_pay_w = '0;
		end else begin : g_body
			assign prev_gt_w  = cell_gt[i-1];
			assign prev_seq_w = cell_seq[i-1];
			assign prev_pay_w = cell_pay[i-1];
		end

		if (i == SLOTS - 1) begin : g_tail
			assign next_seq_w = '0;
			assign next_pay_w = '0;
		end else begin : g_inner
			assign next_seq_w = cell_seq[i+1];
			assign next_pay_w = cell_pay[i+1];
		end

		sro_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occ      (occ[i]),
			.prev_gt  (prev_gt_w),
			.prev_seq (prev_seq_w),
			.prev_pay (prev_pay_w),
			.next_seq (next_seq_w),
			.next_pay (next_pay_w),
			.seq      (cell_seq[i]),
			.pay      (cell_pay[i]),
			.gt       (cell_gt[i]),
			.eq       (cell_eq[i]),
			.link     (cell_link[i])
		);
	end

	// contiguity walk: run of gap-free entries from the head
	logic             head_ok;
	logic [SLOTS-1:0] run;
	logic [SLOTS-1:0] run_end;
	logic [SEQ_W-1:0] walk_seq;

	assign head_ok = occ[0] &&
		($signed({2'b00, cell_seq[0]}) <= (contig_x + (CSEQ_W+1)'(1)));

	always_comb begin
		run[0] = head_ok;
		for (int i = 1; i < SLOTS; i++) begin
			run[i] = run[i-1] && occ[i] && cell_link[i];
		end
	end

	always_comb begin
		walk_seq = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (i == SLOTS - 1) begin
				run_end[i] = run[i];
			end else begin
				run_end[i] = run[i] && !run[i+1];
			end
			walk_seq = walk_seq | (run_end[i] ? cell_seq[i] : '0);
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= '0;
		end else if (cfg_we) begin
			token_q <= cfg_wdata;
		end
	end

	// item execution and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			contig_q  <= '1;
			conn_q    <= '1;
			walk_q    <= 1'b0;
			walk_en_q <= 1'b0;
			done_q    <= 1'b0;
			status_q  <= ST_NONE;
			out_seq_q <= '0;
			out_pay_q <= '0;
		end else begin
			done_q <= walk_q;
			walk_q <= accept;
			if (accept) begin
				out_seq_q <= '0;
				out_pay_q <= '0;
				walk_en_q <= is_recv && !stale;
				case (func)
					FN_RECEIVE: begin
						if (hello_take) begin
							conn_q <= {1'b0, offered_conn_id};
						end
						if (stale) begin
							status_q <= ST_STALE;
						end else if (dup) begin
							status_q <= ST_DUP;
						end else if (full) begin
							status_q <= ST_FULL;
						end else begin
							status_q <= ST_STORED;
							count_q  <= count_q + CNT_W'(1);
						end
					end
					FN_RELEASE: begin
						if (rel_ok) begin
							status_q  <= ST_RELEASED;
							out_seq_q <= cell_seq[0];
							out_pay_q <= cell_pay[0];
							count_q   <= count_q - CNT_W'(1);
						end else begin
							status_q <= ST_NONE;
						end
					end
					FN_RESET: begin
						contig_q <= '1;
						status_q <= ST_RESET;
					end
					default: begin
						status_q <= ST_NONE;
					end
				endcase
			end else if (walk_q && walk_en_q && head_ok) begin
				contig_q <= {1'b0, walk_seq};
			end
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign out_seq        = out_seq_q;
	assign out_payload    = out_pay_q;
	assign contiguous_seq = contig_q;
	assign conn_id        = conn_q;

`ifndef ASSERT_OFF
	a_walk_done: assert property (@(posedge clk) disable iff (!arst_n)
		walk_q |=> done_q)
		else $error("walk cycle did not produce a result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("fill count beyond store depth");

	a_stored_grows: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q == ST_STORED) |-> count_q == $past(count_q, 2) + CNT_W'(1))
		else $error("stored word did not grow the count");

	a_release_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q == ST_RELEASED) |-> count_q == $past(count_q, 2) - CNT_W'(1))
		else $error("released word did not shrink the count");

	a_conn_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(conn_q != '1) |=> $stable(conn_q))
		else $error("connection id changed after assignment");
`endif

endmodule

`default_nettype wire
